>>> rtl/core/echo_escape_decoder_defines.svh
// Assertion macros used by the top-level RTL file of the escape decoder.
`ifndef ECHO_ESCAPE_DECODER_DEFINES_SVH
`define ECHO_ESCAPE_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define EED_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define EED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/eed_pkg.sv
package eed_pkg;

    localparam int MaxResults = 4;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_OCTAL  = 3'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] value;
        logic [1:0] digits;
        logic       stopped;
    } t_dec_state;

    typedef struct packed {
        logic [MaxResults-1:0][7:0] data;
        logic [MaxResults-1:0]      has;
        logic [2:0]                 count;
        logic                       line_done;
    } t_results;

    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_E   = 8'h65;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_V   = 8'h76;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CODE_BEL   = 8'h07;
    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_ESC   = 8'h1B;
    localparam logic [7:0] CODE_FF    = 8'h0C;
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [7:0] CODE_VT    = 8'h0B;

    // Returns a valid flag above the four-bit value of a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= CH_LOW_A && b <= CH_LOW_F) || (b >= CH_UP_A && b <= CH_UP_F)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return b[7:3] == 5'b00110;
    endfunction

endpackage

>>> rtl/core/eed_decode.sv
module eed_decode (
    input  logic                [7:0] i_byte,
    input  logic                      i_has_byte,
    input  logic                      i_arg_end,
    input  eed_pkg::t_dec_state       i_state,
    output eed_pkg::t_dec_state       o_state,
    output eed_pkg::t_results         o_results
);
    import eed_pkg::*;

    t_results   res;
    t_dec_state st;
    logic [2:0] n;
    logic       do_plain;
    logic [4:0] hv;

    assign hv = hex_digit(i_byte);

    always_comb begin
        res      = '0;
        st       = i_state;
        n        = 3'd0;
        do_plain = 1'b0;

        if (i_has_byte && !i_state.stopped) begin
            case (i_state.mode)
                MODE_ESCAPE: begin
                    st.mode = MODE_NORMAL;
                    case (i_byte)
                        CH_LOW_A: begin res.data[n[1:0]] = CODE_BEL; res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_B: begin res.data[n[1:0]] = CODE_BS;  res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_E: begin res.data[n[1:0]] = CODE_ESC; res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_F: begin res.data[n[1:0]] = CODE_FF;  res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_N: begin res.data[n[1:0]] = CODE_LF;  res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_R: begin res.data[n[1:0]] = CODE_CR;  res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_T: begin res.data[n[1:0]] = CODE_TAB; res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_V: begin res.data[n[1:0]] = CODE_VT;  res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_BSL:   begin res.data[n[1:0]] = CH_BSL;   res.has[n[1:0]] = 1'b1; n = n + 3'd1; end
                        CH_LOW_C: begin
                            st.stopped = 1'b1;
                        end
                        CH_LOW_X: begin
                            st.mode   = MODE_HEX;
                            st.value  = 8'd0;
                            st.digits = 2'd0;
                        end
                        default: begin
                            if (is_octal(i_byte)) begin
                                st.mode   = MODE_OCTAL;
                                st.value  = {5'd0, i_byte[2:0]};
                                st.digits = (i_byte == CH_ZERO) ? 2'd0 : 2'd1;
                            end else begin
                                res.data[n[1:0]] = CH_BSL;
                                res.has[n[1:0]]  = 1'b1;
                                n = n + 3'd1;
                                res.data[n[1:0]] = i_byte;
                                res.has[n[1:0]]  = 1'b1;
                                n = n + 3'd1;
                            end
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (hv[4]) begin
                        st.value  = {i_state.value[3:0], hv[3:0]};
                        st.digits = i_state.digits + 2'd1;
                        if (st.digits == 2'd2) begin
                            res.data[n[1:0]] = st.value;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                            st.mode   = MODE_NORMAL;
                            st.digits = 2'd0;
                        end
                    end else begin
                        if (i_state.digits == 2'd0) begin
                            res.data[n[1:0]] = CH_BSL;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                            res.data[n[1:0]] = CH_LOW_X;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                        end else begin
                            res.data[n[1:0]] = i_state.value;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                        end
                        st.mode   = MODE_NORMAL;
                        st.digits = 2'd0;
                        do_plain  = 1'b1;
                    end
                end
                MODE_OCTAL: begin
                    if (is_octal(i_byte)) begin
                        st.value  = {i_state.value[4:0], i_byte[2:0]};
                        st.digits = i_state.digits + 2'd1;
                        if (st.digits == 2'd3) begin
                            res.data[n[1:0]] = st.value;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                            st.mode   = MODE_NORMAL;
                            st.digits = 2'd0;
                        end
                    end else begin
                        res.data[n[1:0]] = i_state.value;
                        res.has[n[1:0]]  = 1'b1;
                        n = n + 3'd1;
                        st.mode   = MODE_NORMAL;
                        st.digits = 2'd0;
                        do_plain  = 1'b1;
                    end
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase

            if (do_plain) begin
                if (i_byte == CH_BSL) begin
                    st.mode = MODE_ESCAPE;
                end else begin
                    res.data[n[1:0]] = i_byte;
                    res.has[n[1:0]]  = 1'b1;
                    n = n + 3'd1;
                end
            end
        end

        if (i_arg_end) begin
            if (st.stopped) begin
                res.data[n[1:0]] = 8'd0;
                res.has[n[1:0]]  = 1'b0;
                n = n + 3'd1;
            end else begin
                case (st.mode)
                    MODE_ESCAPE: begin
                        res.data[n[1:0]] = CH_BSL;
                        res.has[n[1:0]]  = 1'b1;
                        n = n + 3'd1;
                    end
                    MODE_HEX: begin
                        if (st.digits == 2'd0) begin
                            res.data[n[1:0]] = CH_BSL;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                            res.data[n[1:0]] = CH_LOW_X;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                        end else begin
                            res.data[n[1:0]] = st.value;
                            res.has[n[1:0]]  = 1'b1;
                            n = n + 3'd1;
                        end
                    end
                    MODE_OCTAL: begin
                        res.data[n[1:0]] = st.value;
                        res.has[n[1:0]]  = 1'b1;
                        n = n + 3'd1;
                    end
                    default: begin
                    end
                endcase
                res.data[n[1:0]] = CODE_LF;
                res.has[n[1:0]]  = 1'b1;
                n = n + 3'd1;
            end
            res.line_done = 1'b1;
            st = '{mode: MODE_NORMAL, value: 8'd0, digits: 2'd0, stopped: 1'b0};
        end

        res.count = n;
    end

    assign o_state   = st;
    assign o_results = res;

endmodule

>>> rtl/core/echo_escape_decoder.sv
// Echo-style escape decoder: each accepted input beat carries one byte of an argument (or
// only an end mark) and produces zero to four output beats, decoded combinationally into
// a four-entry result register that drains one beat per cycle while i_out_ready is high.
// A beat that yields at most one result beat is taken every cycle at full throughput while
// the output is ready; a beat that yields more holds the input off while the register drains.
// The input is also taken in the same cycle in which the last pending result beat leaves.
`include "echo_escape_decoder_defines.svh"

module echo_escape_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_has_byte,
    input  logic       i_arg_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_has_byte,
    output logic       o_line_done
);
    import eed_pkg::*;

    t_dec_state r_state;
    t_dec_state n_state;
    t_results   n_results;

    logic [MaxResults-1:0][7:0] r_data;
    logic [MaxResults-1:0]      r_has;
    logic [2:0]                 r_left;
    logic [1:0]                 r_idx;
    logic                       r_line;

    logic in_accept;
    logic out_beat;
    logic last_beat;

    eed_decode u_decode (
        .i_byte     (i_in_byte),
        .i_has_byte (i_in_has_byte),
        .i_arg_end  (i_arg_end),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_results  (n_results)
    );

    assign o_out_valid    = (r_left != 3'd0);
    assign last_beat      = (r_left == 3'd1);
    assign out_beat       = o_out_valid && i_out_ready;
    assign o_in_ready     = !o_out_valid || (out_beat && last_beat);
    assign in_accept      = i_in_valid && o_in_ready;
    assign o_out_byte     = r_data[r_idx];
    assign o_out_has_byte = r_has[r_idx];
    assign o_line_done    = r_line && last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_NORMAL, value: 8'd0, digits: 2'd0, stopped: 1'b0};
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 2'd0;
            r_line <= 1'b0;
        end else if (in_accept) begin
            r_left <= n_results.count;
            r_idx  <= 2'd0;
            r_line <= n_results.line_done;
        end else if (out_beat) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data <= n_results.data;
            r_has  <= n_results.has;
        end
    end

    `EED_ASSERT_IMPLY(a_bare_marker_ends_line, i_clk, i_rst_n, o_out_valid && !o_out_has_byte, o_line_done)
    `EED_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `EED_ASSERT_IMPLY(a_left_bounded, i_clk, i_rst_n, 1'b1, r_left <= 3'd4)
    `EED_ASSERT_NEXT(a_end_clears_state, i_clk, i_rst_n, in_accept && i_arg_end, r_state.mode == MODE_NORMAL && !r_state.stopped && r_state.value == 8'd0)

endmodule

>>> tb/sv/tb_echo_escape_decoder.sv
`timescale 1ns / 1ps

module tb_echo_escape_decoder;
    import eed_pkg::*;

    localparam int unsigned CycleLimit = 200000;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       done;
    } t_out_beat;

    class escape_scoreboard;
        t_mode      mode;
        logic [7:0] acc;
        logic [1:0] ndig;
        logic       stopped;
        t_out_beat  expected_q[$];
        int         errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            mode    = MODE_NORMAL;
            acc     = '0;
            ndig    = '0;
            stopped = 1'b0;
        endfunction

        function void push(logic [7:0] b, logic has = 1'b1);
            t_out_beat e;
            e.data = b;
            e.has  = has;
            e.done = 1'b0;
            expected_q = {expected_q, e};
        endfunction

        function int hex_weight(logic [7:0] b);
            if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
            if (b >= CH_LOW_A && b <= CH_LOW_F) return int'(b - CH_LOW_A) + 10;
            if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
            return -1;
        endfunction

        function void plain_text(logic [7:0] b);
            if (b == CH_BSL) begin
                mode = MODE_ESCAPE;
            end else begin
                push(b);
            end
        endfunction

        function void after_backslash(logic [7:0] b);
            mode = MODE_NORMAL;
            case (b)
                CH_LOW_A: push(CODE_BEL);
                CH_LOW_B: push(CODE_BS);
                CH_LOW_E: push(CODE_ESC);
                CH_LOW_F: push(CODE_FF);
                CH_LOW_N: push(CODE_LF);
                CH_LOW_R: push(CODE_CR);
                CH_LOW_T: push(CODE_TAB);
                CH_LOW_V: push(CODE_VT);
                CH_BSL:   push(CH_BSL);
                CH_LOW_C: stopped = 1'b1;
                CH_LOW_X: begin
                    mode = MODE_HEX;
                    acc  = '0;
                    ndig = '0;
                end
                default: begin
                    if (b >= CH_ZERO && b <= CH_SEVEN) begin
                        mode = MODE_OCTAL;
                        acc  = b - CH_ZERO;
                        ndig = (b == CH_ZERO) ? 2'd0 : 2'd1;
                    end else begin
                        push(CH_BSL);
                        push(b);
                    end
                end
            endcase
        endfunction

        function void hex_text(logic [7:0] b);
            int h;
            h = hex_weight(b);
            if (h >= 0) begin
                acc  = {acc[3:0], h[3:0]};
                ndig = ndig + 2'd1;
                if (ndig >= 2'd2) begin
                    push(acc);
                    mode = MODE_NORMAL;
                    ndig = '0;
                end
            end else begin
                if (ndig == 2'd0) begin
                    push(CH_BSL);
                    push(CH_LOW_X);
                end else begin
                    push(acc);
                end
                mode = MODE_NORMAL;
                ndig = '0;
                plain_text(b);
            end
        endfunction

        function void octal_text(logic [7:0] b);
            if (b >= CH_ZERO && b <= CH_SEVEN) begin
                acc  = (acc << 3) + (b - CH_ZERO);
                ndig = ndig + 2'd1;
                if (ndig == 2'd3) begin
                    push(acc);
                    mode = MODE_NORMAL;
                    ndig = '0;
                end
            end else begin
                push(acc);
                mode = MODE_NORMAL;
                ndig = '0;
                plain_text(b);
            end
        endfunction

        function void note_input(logic [7:0] b, logic has, logic fin);
            if (has && !stopped) begin
                case (mode)
                    MODE_ESCAPE: after_backslash(b);
                    MODE_HEX:    hex_text(b);
                    MODE_OCTAL:  octal_text(b);
                    default:     plain_text(b);
                endcase
            end
            if (fin) begin
                if (stopped) begin
                    push(8'h00, 1'b0);
                end else begin
                    case (mode)
                        MODE_ESCAPE: push(CH_BSL);
                        MODE_HEX: begin
                            if (ndig == 2'd0) begin
                                push(CH_BSL);
                                push(CH_LOW_X);
                            end else begin
                                push(acc);
                            end
                        end
                        MODE_OCTAL: push(acc);
                        default: ;
                    endcase
                    push(CODE_LF);
                end
                expected_q[$].done = 1'b1;
                clear_state();
            end
        endfunction

        function void check_result(logic [7:0] b, logic has, logic done);
            t_out_beat e;
            if (expected_q.size() == 0) begin
                $error("unexpected output beat: out_byte %h out_has_byte %b line_done %b",
                       b, has, done);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (b !== e.data) begin
                $error("out_byte: expected %h, actual %h", e.data, b);
                errors++;
            end
            if (has !== e.has) begin
                $error("out_has_byte: expected %b, actual %b", e.has, has);
                errors++;
            end
            if (done !== e.done) begin
                $error("line_done: expected %b, actual %b", e.done, done);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_has_byte = 1'b0;
    logic       i_arg_end = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_has_byte;
    logic       o_line_done;

    escape_scoreboard sb;
    int          send_idle_max = 11;
    int          recv_idle_max = 11;
    int          items_sent = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  arg_text[$];
    logic [7:0]  named_esc[9] = '{CH_LOW_A, CH_LOW_B, CH_LOW_E, CH_LOW_F, CH_LOW_N,
                                  CH_LOW_R, CH_LOW_T, CH_LOW_V, CH_BSL};

    echo_escape_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_in_has_byte  (i_in_has_byte),
        .i_arg_end      (i_arg_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_out_has_byte (o_out_has_byte),
        .o_line_done    (o_line_done)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("tb_echo_escape_decoder: done, errors");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic has, input logic fin);
        int gap;
        gap = $urandom_range(send_idle_max, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_in_has_byte <= has;
        i_arg_end     <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(b, has, fin);
        if (has || fin) items_sent++;
    endtask

    task automatic take_beat();
        int gap;
        gap = $urandom_range(recv_idle_max, 0);
        if (gap > 0) begin
            i_out_ready <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_out_ready <= 1'b1;
        do @(posedge i_clk); while (!o_out_valid);
        sb.check_result(o_out_byte, o_out_has_byte, o_line_done);
    endtask

    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_beat(s[k], 1'b1, k == s.len() - 1);
        end
    endtask

    function automatic void add_char(input logic [7:0] c);
        arg_text = {arg_text, c};
    endfunction

    task automatic add_token();
        int kind;
        int n;
        kind = $urandom_range(99, 0);
        if (kind < 30) begin
            add_char($urandom_range(1, 0) ? 8'($urandom_range(126, 32)) : 8'($urandom));
        end else if (kind < 50) begin
            add_char(CH_BSL);
            add_char(named_esc[$urandom_range(8, 0)]);
        end else if (kind < 62) begin
            add_char(CH_BSL);
            add_char(CH_LOW_X);
            repeat ($urandom_range(2, 0)) begin
                n = $urandom_range(21, 0);
                if (n < 10) begin
                    add_char(CH_ZERO + 8'(n));
                end else if (n < 16) begin
                    add_char(CH_LOW_A + 8'(n - 10));
                end else begin
                    add_char(CH_UP_A + 8'(n - 16));
                end
            end
        end else if (kind < 80) begin
            add_char(CH_BSL);
            add_char(CH_ZERO + 8'($urandom_range(7, 0)));
            repeat ($urandom_range(3, 0)) add_char(CH_ZERO + 8'($urandom_range(7, 0)));
        end else if (kind < 90) begin
            add_char(CH_BSL);
            add_char(8'($urandom));
        end else if (kind < 95) begin
            add_char(CH_BSL);
            add_char(CH_LOW_C);
        end else begin
            add_char(CH_BSL);
        end
    endtask

    task automatic send_random_arg();
        int ntok;
        bit split_end;
        arg_text.delete();
        ntok = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 0) : $urandom_range(5, 0);
        repeat (ntok) add_token();
        split_end = (arg_text.size() == 0) || ($urandom_range(3, 0) == 0);
        foreach (arg_text[k]) begin
            if ($urandom_range(9, 0) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(arg_text[k], 1'b1, !split_end && k == arg_text.size() - 1);
        end
        if (split_end) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever take_beat();
    end

    initial begin
        int quota;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'hA5, 1'b0, 1'b1);
        send_beat(8'h5A, 1'b0, 1'b0);
        send_string("\\xg");
        send_string("\\777");
        send_string("\\xf");
        send_beat(CH_BSL, 1'b1, 1'b0);
        send_beat(CH_LOW_C, 1'b1, 1'b0);
        send_beat(8'h7A, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);
        send_string("\\");
        send_string("\\019");
        send_string("\\q");

        // The sender holds off here until every expected beat has come back.
        wait_drained();

        for (int seg = 0; seg < 4; seg++) begin
            send_idle_max = (seg == 1 || seg == 3) ? 11 : 0;
            recv_idle_max = (seg == 1 || seg == 2) ? 11 : 0;
            quota = items_sent + 65;
            while (items_sent < quota) send_random_arg();
            if (seg == 1) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_echo_escape_decoder: done, clean");
        end else begin
            $display("tb_echo_escape_decoder: done, errors");
        end
        $finish;
    end
endmodule
